### rtl/core/id_number_check_digit_validator_unit_defines.svh
`ifndef ID_NUMBER_CHECK_DIGIT_VALIDATOR_UNIT_DEFINES_SVH
`define ID_NUMBER_CHECK_DIGIT_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("idv check failed: same-cycle rule");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("idv check failed: next-cycle rule");

`endif

### rtl/core/idv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idv_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_X_LC  = 8'h78;
  localparam logic [7:0] CHAR_X_UC  = 8'h58;

  localparam logic [4:0] POS_SHORT_LEN = 5'd15;
  localparam logic [4:0] POS_SHORT_END = 5'd14;
  localparam logic [4:0] POS_LONG_END  = 5'd17;
  localparam logic [4:0] POS_MAX       = 5'd19;
  localparam logic [4:0] POS_FIRST     = 5'd0;
  localparam logic [4:0] POS_MON_TENS  = 5'd8;
  localparam logic [4:0] POS_MON_UNITS = 5'd9;
  localparam logic [4:0] POS_DAY_TENS  = 5'd10;
  localparam logic [4:0] POS_DAY_UNITS = 5'd11;

  localparam logic [3:0] CHECK_TEN = 4'd10;

  typedef struct packed {
    logic [4:0] pos;
    logic [3:0] residue;
    logic       short_ok;
    logic       long_ok;
    logic       mon_one;
    logic       day_three;
  } idv_state_t;

  localparam idv_state_t STATE_RESET = '{
    pos: 5'd0, residue: 4'd0, short_ok: 1'b1, long_ok: 1'b1,
    mon_one: 1'b0, day_three: 1'b0
  };

  function automatic logic [3:0] weight_of(input logic [4:0] p);
    logic [3:0] w;
    case (p)
      5'd0, 5'd10:  w = 4'd7;
      5'd1, 5'd11:  w = 4'd9;
      5'd2, 5'd12:  w = 4'd10;
      5'd3, 5'd13:  w = 4'd5;
      5'd4, 5'd14:  w = 4'd8;
      5'd5, 5'd15:  w = 4'd4;
      5'd6, 5'd16:  w = 4'd2;
      5'd7:         w = 4'd1;
      5'd8:         w = 4'd6;
      5'd9:         w = 4'd3;
      default:      w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] check_of(input logic [3:0] r);
    logic [3:0] c;
    case (r)
      4'd0:    c = 4'd1;
      4'd1:    c = 4'd0;
      4'd2:    c = 4'd10;
      4'd3:    c = 4'd9;
      4'd4:    c = 4'd8;
      4'd5:    c = 4'd7;
      4'd6:    c = 4'd6;
      4'd7:    c = 4'd5;
      4'd8:    c = 4'd4;
      4'd9:    c = 4'd3;
      4'd10:   c = 4'd2;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  // Remainder by 11 for values up to 100: quotient by reciprocal 187/2048.
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'd187;
    q    = prod[14:11];
    r    = v - 7'(q) * 7'd11;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/idv_step.sv
`timescale 1ns / 1ps
`default_nettype none

module idv_step
  import idv_pkg::*;
(
  input  wire idv_state_t state_i,
  input  wire logic [7:0] char_i,
  input  wire logic       last_i,
  output idv_state_t      state_o,
  output logic            verdict_o
);

  logic       is_digit;
  logic [3:0] digit;
  logic       fits;
  logic       s_ok;
  logic       l_ok;
  logic [3:0] res;
  logic [6:0] prod;
  logic [6:0] sum;
  logic [3:0] want;
  logic       want_ok;

  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign digit    = char_i[3:0];
  assign prod     = 7'(digit) * 7'(weight_of(state_i.pos));
  assign sum      = prod + 7'(state_i.residue);

  always_comb begin
    case (state_i.pos)
      POS_FIRST:     fits = (char_i != CHAR_ZERO);
      POS_MON_TENS:  fits = (char_i <= CHAR_ONE);
      POS_MON_UNITS: fits = !state_i.mon_one || (char_i <= CHAR_TWO);
      POS_DAY_TENS:  fits = (char_i <= CHAR_THREE);
      POS_DAY_UNITS: fits = !state_i.day_three || (char_i <= CHAR_ONE);
      default:       fits = 1'b1;
    endcase
  end

  always_comb begin
    s_ok = state_i.short_ok;
    if (state_i.pos < POS_SHORT_LEN) begin
      s_ok = state_i.short_ok && is_digit && fits;
    end
    l_ok = state_i.long_ok;
    res  = state_i.residue;
    if (state_i.pos < POS_LONG_END) begin
      if (is_digit) begin
        res = mod11(sum);
      end else begin
        l_ok = 1'b0;
      end
    end
  end

  always_comb begin
    want    = digit;
    want_ok = is_digit;
    if ((char_i == CHAR_X_LC) || (char_i == CHAR_X_UC)) begin
      want    = CHECK_TEN;
      want_ok = 1'b1;
    end
  end

  always_comb begin
    verdict_o = 1'b0;
    if (state_i.pos == POS_SHORT_END) begin
      verdict_o = s_ok;
    end else if (state_i.pos == POS_LONG_END) begin
      verdict_o = l_ok && want_ok && (check_of(res) == want);
    end
  end

  // Restart the string after its last character; otherwise advance.
  always_comb begin
    if (last_i) begin
      state_o = STATE_RESET;
    end else begin
      state_o.pos       = (state_i.pos < POS_MAX) ? state_i.pos + 5'd1 : POS_MAX;
      state_o.residue   = res;
      state_o.short_ok  = s_ok;
      state_o.long_ok   = l_ok;
      state_o.mon_one   = (state_i.pos == POS_MON_TENS) ? (char_i == CHAR_ONE)
                                                        : state_i.mon_one;
      state_o.day_three = (state_i.pos == POS_DAY_TENS) ? (char_i == CHAR_THREE)
                                                        : state_i.day_three;
    end
  end

endmodule

`default_nettype wire

### rtl/core/id_number_check_digit_validator_unit.sv
// Identity number validator, one ASCII character per request.
// Slave channel: s_axis_tdata carries one character, s_axis_tlast marks the
// final character of a string. Master channel: one request per string, sent
// when its last character has been processed; m_axis_tdata bit 0 is 1 when
// the string is a valid 15-character or 18-character identity number.
// A character accepted into the input register is folded into the string
// state when it leaves that register; a last character leaves it only when
// the master side is free, and its verdict then goes to the output register.
// Throughput: one character per cycle unless a last character is held up,
// set by the combinational residue multiply-add mod 11 and format compares.
// Stall: while a verdict waits on m_axis_tready, characters that do not end a
// string still flow; a second last character waits in the input register and
// s_axis_tready drops until the master side frees up.
// Reset (rst_ni low, asynchronous): both channels empty, string state back to
// position zero, residue zero, ok flags set and month and day flags clear.
`timescale 1ns / 1ps
`default_nettype none

module id_number_check_digit_validator_unit
  import idv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] character
  input  wire logic       s_axis_tlast,   // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] valid_res, [7:1] zero
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  idv_state_t state_q;
  idv_state_t state_d;
  logic       out_valid_q;
  logic       out_res_q;
  logic       verdict;
  logic       out_free;
  logic       fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || fire;

  idv_step u_step (
    .state_i   (state_q),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .state_o   (state_d),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_res_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q};

endmodule

`default_nettype wire

### rtl/core/idv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "id_number_check_digit_validator_unit_defines.svh"

module idv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic s_hold;

  // Flag a stalled slave request whose character is nonzero or whose last mark is set.
  assign s_hold = s_axis_tvalid && !s_axis_tready && (s_axis_tdata != 8'd0 || s_axis_tlast);

  `IDV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `IDV_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `IDV_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
  `IDV_ASSERT_NOW(a_ready_free, s_hold || !m_axis_tvalid || m_axis_tready, s_axis_tready || s_hold)

endmodule

bind id_number_check_digit_validator_unit idv_checker u_idv_checker (.*);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import idv_pkg::*;

  localparam int unsigned CHAR_TOTAL  = 1500;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int          CHECK_MOD   = 11;
  localparam int          LONG_BODY   = 17;
  localparam bit [3:0] WEIGHTS [17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
  localparam bit [3:0] CHECK_DIGITS [11] = '{1, 0, 10, 9, 8, 7, 6, 5, 4, 3, 2};

  // Tracks the string in flight and the verdicts still owed by the block.
  class verdict_board;
    bit [4:0]    pos;
    bit [3:0]    residue;
    bit          short_ok;
    bit          long_ok;
    bit          mon_one;
    bit          day_three;
    bit          pending_verdicts[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      pos       = '0;
      residue   = '0;
      short_ok  = 1'b1;
      long_ok   = 1'b1;
      mon_one   = 1'b0;
      day_three = 1'b0;
    endfunction

    function bit is_digit(bit [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function bit fits_short_form(bit [4:0] p, bit [7:0] c);
      if (!is_digit(c)) return 1'b0;
      case (p)
        POS_FIRST:     return c != CHAR_ZERO;
        POS_MON_TENS:  return c <= CHAR_ONE;
        POS_MON_UNITS: return !mon_one || c <= CHAR_TWO;
        POS_DAY_TENS:  return c <= CHAR_THREE;
        POS_DAY_UNITS: return !day_three || c <= CHAR_ONE;
        default:       return 1'b1;
      endcase
    endfunction

    // Fold one accepted character; a last character queues the verdict.
    function void take_char(bit [7:0] c, bit lst);
      bit [4:0] p;
      bit       s_ok;
      bit       l_ok;
      bit       verdict;
      int       r;
      int       want;
      p    = pos;
      s_ok = short_ok;
      l_ok = long_ok;
      r    = residue;
      if (p < POS_SHORT_LEN) s_ok = s_ok && fits_short_form(p, c);
      if (p < POS_LONG_END) begin
        if (is_digit(c)) r = (r + int'(c - CHAR_ZERO) * int'(WEIGHTS[p])) % CHECK_MOD;
        else l_ok = 1'b0;
      end
      if (lst) begin
        verdict = 1'b0;
        if (p == POS_SHORT_END) begin
          verdict = s_ok;
        end else if (p == POS_LONG_END) begin
          if (c == CHAR_X_LC || c == CHAR_X_UC) want = int'(CHECK_TEN);
          else if (is_digit(c)) want = int'(c - CHAR_ZERO);
          else want = -1;
          verdict = l_ok && want == int'(CHECK_DIGITS[r]);
        end
        pending_verdicts.insert(pending_verdicts.size(), verdict);
        clear_string();
      end else begin
        if (p == POS_MON_TENS) mon_one = (c == CHAR_ONE);
        if (p == POS_DAY_TENS) day_three = (c == CHAR_THREE);
        short_ok = s_ok;
        long_ok  = l_ok;
        residue  = 4'(r);
        if (p < POS_MAX) pos = p + 5'd1;
      end
    endfunction

    function void check_verdict(logic [7:0] got);
      logic [7:0] want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict with none pending, expected none, got %0h", $time, got);
        mismatches++;
        return;
      end
      want = {7'd0, pending_verdicts.pop_front()};
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0h, got %0h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  verdict_board board = new();
  bit [7:0]     text[$];
  int unsigned  sent_chars = 0;
  int unsigned  send_idle_pct = 6;
  int unsigned  recv_idle_pct = 86;
  int unsigned  quiet_cycles = 0;

  id_number_check_digit_validator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
  end

  // End the run when neither side has moved a request for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[id_number_check_digit_validator_unit] ERROR");
      $finish;
    end
  end

  function automatic bit [7:0] pick(bit [7:0] lo, bit [7:0] hi);
    return lo + 8'($urandom_range(hi - lo));
  endfunction

  function automatic bit [7:0] any_digit();
    return pick(CHAR_ZERO, CHAR_NINE);
  endfunction

  function automatic void add_char(bit [7:0] c);
    text.insert(text.size(), c);
  endfunction

  // Mostly well-formed 15-character strings; each constrained slot strays now and then.
  task automatic build_short_form();
    bit [7:0] mt;
    bit [7:0] dt;
    text.delete();
    add_char(($urandom_range(9) == 0) ? any_digit() : pick(CHAR_ONE, CHAR_NINE));
    repeat (7) add_char(any_digit());
    mt = ($urandom_range(9) == 0) ? any_digit() : pick(CHAR_ZERO, CHAR_ONE);
    add_char(mt);
    if (mt == CHAR_ONE && $urandom_range(9) != 0) add_char(pick(CHAR_ZERO, CHAR_TWO));
    else add_char(any_digit());
    dt = ($urandom_range(9) == 0) ? any_digit() : pick(CHAR_ZERO, CHAR_THREE);
    add_char(dt);
    if (dt == CHAR_THREE && $urandom_range(9) != 0) add_char(pick(CHAR_ZERO, CHAR_ONE));
    else add_char(any_digit());
    repeat (3) add_char(any_digit());
  endtask

  // 18-character string with the matching check character.
  task automatic build_long_form();
    int       r;
    bit [3:0] chk;
    text.delete();
    r = 0;
    for (int i = 0; i < LONG_BODY; i++) begin
      add_char(any_digit());
      r = (r + int'(text[i] - CHAR_ZERO) * int'(WEIGHTS[i])) % CHECK_MOD;
    end
    chk = CHECK_DIGITS[r];
    if (chk == CHECK_TEN) add_char($urandom_range(1) ? CHAR_X_UC : CHAR_X_LC);
    else add_char(CHAR_ZERO + 8'(chk));
  endtask

  task automatic build_noise();
    int unsigned n;
    bit          digits_only;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(13, 20);
    digits_only = $urandom_range(1);
    text.delete();
    repeat (n) add_char(digits_only ? any_digit() : 8'($urandom));
  endtask

  // Break a well-formed string in one place.
  task automatic mangle_text();
    int unsigned k;
    k = $urandom_range(text.size() - 1);
    case ($urandom_range(4))
      0: text[k] = any_digit();
      1: text[k] = 8'($urandom);
      2: text[text.size() - 1] = any_digit();
      3: void'(text.pop_back());
      default: add_char(any_digit());
    endcase
  endtask

  task automatic send_char(input bit [7:0] ch, input bit lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_char(ch, lst);
    sent_chars++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // Hold off the sender until every verdict owed has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (board.pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned kind;
    int unsigned phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    phase         = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a one-character string of 0xFF, a two-character string opening with 0x00, then a check of ten.
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(CHAR_ZERO, 1'b1);
    do build_long_form(); while (text[LONG_BODY] != CHAR_X_UC && text[LONG_BODY] != CHAR_X_LC);
    text[LONG_BODY] = CHAR_X_UC;
    send_text();

    while (sent_chars < CHAR_TOTAL) begin
      kind = $urandom_range(99);
      if (kind < 35) build_short_form();
      else if (kind < 70) build_long_form();
      else build_noise();
      if (kind < 70 && $urandom_range(2) == 0) mangle_text();
      send_text();
      if (phase == 0 && sent_chars >= CHAR_TOTAL / 3) begin
        drain();
        send_idle_pct = 86;
        recv_idle_pct = 6;
        phase = 1;
      end else if (phase == 1 && sent_chars >= 2 * CHAR_TOTAL / 3) begin
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("[id_number_check_digit_validator_unit] OK");
    end else begin
      $display("[id_number_check_digit_validator_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/idv_pkg.sv
rtl/core/idv_step.sv
rtl/core/id_number_check_digit_validator_unit.sv
rtl/core/idv_checker.sv
verif/tb_top.sv
